FILE: hw/rtl/wrhp_pkg.sv
// Shared types and constants for the WAV RIFF header parser.
// No dependencies; all other hw/rtl files but wrhp_stream_if use it by scoped names.
`default_nettype none

package wrhp_pkg;

	// Descriptor status codes
	localparam logic [3:0] STATUS_OK         = 4'd0;
	localparam logic [3:0] STATUS_BAD_HEADER = 4'd1;
	localparam logic [3:0] STATUS_TRUNCATED  = 4'd2;
	localparam logic [3:0] STATUS_FMT_SHORT  = 4'd3;
	localparam logic [3:0] STATUS_NO_FMT     = 4'd4;
	localparam logic [3:0] STATUS_NO_DATA    = 4'd5;
	localparam logic [3:0] STATUS_NOT_PCM    = 4'd6;
	localparam logic [3:0] STATUS_BAD_PCM    = 4'd7;
	localparam logic [3:0] STATUS_UNALIGNED  = 4'd8;

	// Four-character chunk ids, first byte in the top lane
	localparam logic [31:0] ID_RIFF = 32'h5249_4646;
	localparam logic [31:0] ID_WAVE = 32'h5741_5645;
	localparam logic [31:0] ID_FMT  = 32'h666D_7420;
	localparam logic [31:0] ID_DATA = 32'h6461_7461;

	localparam int OFFSET_W    = 33;   // byte count within a header or body
	localparam int DESC_POS_W  = 40;   // width of payload_offset
	localparam int DIVIDEND_W  = 32;
	localparam int BLOCK_W     = 29;   // channels (16 bits) times bytes per sample (13 bits)
	localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);

	localparam logic [OFFSET_W-1:0] RIFF_ID_END   = 33'd3;
	localparam logic [OFFSET_W-1:0] FILE_HDR_END  = 33'd11;
	localparam logic [OFFSET_W-1:0] CHUNK_ID_LEN  = 33'd4;
	localparam logic [OFFSET_W-1:0] CHUNK_HDR_LEN = 33'd8;
	localparam logic [31:0]         FMT_MIN_SIZE  = 32'd16;
	localparam logic [15:0]         FORMAT_PCM    = 16'd1;

	// Parse phase, one-hot
	typedef enum logic [3:0] {
		PH_FILE = 4'b0001,
		PH_HEAD = 4'b0010,
		PH_BODY = 4'b0100,
		PH_PAD  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [3:0]            status;
		logic [15:0]           format_tag;
		logic [15:0]           channel_count;
		logic [31:0]           sample_rate;
		logic [15:0]           sample_bits;
		logic [DESC_POS_W-1:0] payload_offset;
		logic [31:0]           payload_size;
		logic [31:0]           frame_total;
	} desc_item_t;

	// Controller to datapath
	typedef struct packed {
		logic consume;    // an input item is accepted this cycle
		logic check;      // evaluate end-of-file checks, form the frame size
		logic div_start;  // launch the frame count division
		logic emit;       // load the descriptor and clear the parse state
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wrhp_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
// Payload type is a parameter; the parser uses the item structs of wrhp_pkg.
`default_nettype none

interface wrhp_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wav_riff_header_parser.sv
// WAV RIFF header parser, top level. Byte items are taken one per cycle while
// walking; the last_byte item is followed by the check, start, wait and emit
// states and a one-bit-per-cycle 32-step division before its descriptor is
// registered. Bytes are refused meanwhile; a waiting descriptor not yet taken
// holds back the next. Async active-low reset clears parse state, controller
// and output valid. Depends on wrhp_pkg, wrhp_stream_if, wrhp_ctrl, wrhp_datapath.
`default_nettype none

module wav_riff_header_parser #(
	parameter int POSITION_BITS = 40
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	wrhp_stream_if.sink     bytes,
	wrhp_stream_if.source   descriptor
);
	wrhp_pkg::ctrl_cmd_t  cmd;
	wrhp_pkg::dp_status_t dp_status;
	wrhp_pkg::byte_item_t in_item;
	wrhp_pkg::desc_item_t out_item;
	logic                 in_ready;
	logic                 out_valid;

	// Unpack the byte channel; the controller owns ready
	assign in_item     = bytes.data;
	assign bytes.ready = in_ready;

	// Controller: one byte per cycle while walking, then sequence the
	// end-of-file checks, the division and the descriptor hand-off
	wrhp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bytes.valid),
		.in_last  (in_item.last_byte),
		.in_ready (in_ready),
		.status   (dp_status),
		.cmd      (cmd)
	);

	// Datapath: chunk walk, captured fields, divider, output register
	wrhp_datapath #(
		.POSITION_BITS (POSITION_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (dp_status),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (descriptor.ready),
		.out_item  (out_item)
	);

	// Drive the descriptor channel from the output register
	assign descriptor.valid = out_valid;
	assign descriptor.data  = out_item;

endmodule

`default_nettype wire

FILE: hw/rtl/wrhp_divider.sv
// Restoring divider, one quotient bit per cycle, for the frame count.
// Depends on wrhp_pkg for widths.
`default_nettype none

module wrhp_divider (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [wrhp_pkg::DIVIDEND_W-1:0] dividend,
	input  wire logic [wrhp_pkg::BLOCK_W-1:0]    divisor,
	output logic                                 done,
	output logic [wrhp_pkg::DIVIDEND_W-1:0]      quotient,
	output logic [wrhp_pkg::DIVIDEND_W-1:0]      remainder
);
	logic                             busy_q;
	logic                             done_q;
	logic [wrhp_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [wrhp_pkg::DIVIDEND_W-1:0]  quo_q;
	logic [wrhp_pkg::DIVIDEND_W-1:0]  rem_q;
	logic [wrhp_pkg::DIVIDEND_W:0]    partial;
	logic [wrhp_pkg::DIVIDEND_W:0]    diff;

	assign partial = {rem_q, quo_q[wrhp_pkg::DIVIDEND_W-1]};
	assign diff    = partial - (wrhp_pkg::DIVIDEND_W + 1)'(divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wrhp_pkg::DIV_CNT_W'(wrhp_pkg::DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			// keep the trial difference when it did not borrow
			if (!diff[wrhp_pkg::DIVIDEND_W]) begin
				rem_q <= diff[wrhp_pkg::DIVIDEND_W-1:0];
			end else begin
				rem_q <= partial[wrhp_pkg::DIVIDEND_W-1:0];
			end
			quo_q <= {quo_q[wrhp_pkg::DIVIDEND_W-2:0], ~diff[wrhp_pkg::DIVIDEND_W]};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

`default_nettype wire

FILE: hw/rtl/wrhp_ctrl.sv
// Controller state machine of the header parser: byte intake, end-of-file
// sequencing, descriptor hand-off. Depends on wrhp_pkg.
`default_nettype none

module wrhp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_last,
	output logic                  in_ready,
	input  wrhp_pkg::dp_status_t  status,
	output wrhp_pkg::ctrl_cmd_t   cmd
);
	typedef enum logic [4:0] {
		ST_RUN   = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_START = 5'b00100,
		ST_WAIT  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_n;

	always_comb begin
		state_n       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		case (state_q)
			ST_RUN: begin
				in_ready    = 1'b1;
				cmd.consume = in_valid;
				if (in_valid && in_last) begin
					state_n = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_n   = ST_START;
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_n       = ST_WAIT;
			end
			ST_WAIT: begin
				if (status.div_done) begin
					state_n = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// hold until the output register is free
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_n  = ST_RUN;
				end
			end
			default: begin
				state_n = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_n;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !status.out_busy)
		else $error("descriptor emitted over a waiting one");

	a_done_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT && status.div_done) |=> (state_q == ST_EMIT))
		else $error("division result not taken");

endmodule

`default_nettype wire

FILE: hw/rtl/wrhp_datapath.sv
// Datapath of the header parser: chunk walk registers, captured fields,
// end-of-file checks, frame count division, descriptor register.
// Depends on wrhp_pkg and wrhp_divider.
`default_nettype none

module wrhp_datapath #(
	parameter int POSITION_BITS = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wrhp_pkg::ctrl_cmd_t       cmd,
	output wrhp_pkg::dp_status_t      status,
	input  wrhp_pkg::byte_item_t      in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output wrhp_pkg::desc_item_t      out_item
);
	localparam int EXT_W = POSITION_BITS + wrhp_pkg::DESC_POS_W;

	logic [POSITION_BITS-1:0]          pos_q, pos_n, next_pos;
	wrhp_pkg::phase_t                  phase_q, phase_n;
	logic [31:0]                       id_q, id_n, size_q, size_n;
	logic [wrhp_pkg::OFFSET_W-1:0]     off_q, off_n, off_inc;
	logic [15:0]                       fmt_q, fmt_n, ch_q, ch_n, bits_q, bits_n;
	logic [31:0]                       rate_q, rate_n;
	logic [wrhp_pkg::DESC_POS_W-1:0]   coff_q, coff_n;
	logic [31:0]                       csize_q, csize_n;
	logic                              seen_fmt_q, seen_fmt_n, seen_data_q, seen_data_n;
	logic                              pend_q, pend_n;
	logic [3:0]                        err_q, err_n;
	logic [31:0]                       id_shift, size_shift, hdr_id, hdr_size;
	logic [EXT_W-1:0]                  pos_ext;
	logic [7:0]                        b;

	logic [3:0]                        pre_err_q, pre_err;
	logic [wrhp_pkg::BLOCK_W-1:0]      block_q;
	logic                              div_done;
	logic [31:0]                       quotient, remainder;

	logic                              out_valid_q;
	wrhp_pkg::desc_item_t              out_q, desc_n;
	logic [3:0]                        final_status;
	logic                              show_fields;

	assign b          = in_item.byte_value;
	assign next_pos   = (&pos_q) ? pos_q : pos_q + 1'b1;
	assign pos_ext    = EXT_W'(next_pos);
	assign id_shift   = {id_q[23:0], b};
	assign size_shift = {b, size_q[31:8]};
	assign off_inc    = off_q + 1'b1;
	assign hdr_id     = (off_q < wrhp_pkg::CHUNK_ID_LEN) ? id_shift : id_q;
	assign hdr_size   = (off_q < wrhp_pkg::CHUNK_ID_LEN) ? size_q : size_shift;

	// Byte consumption: one step of the chunk walk per accepted item
	always_comb begin
		pos_n       = pos_q;
		phase_n     = phase_q;
		id_n        = id_q;
		size_n      = size_q;
		off_n       = off_q;
		fmt_n       = fmt_q;
		ch_n        = ch_q;
		rate_n      = rate_q;
		bits_n      = bits_q;
		coff_n      = coff_q;
		csize_n     = csize_q;
		seen_fmt_n  = seen_fmt_q;
		seen_data_n = seen_data_q;
		pend_n      = pend_q;
		err_n       = err_q;
		if (cmd.consume) begin
			pos_n = next_pos;
			if (err_q == wrhp_pkg::STATUS_OK) begin
				case (phase_q)
					wrhp_pkg::PH_FILE: begin
						id_n = id_shift;
						if (off_q == wrhp_pkg::RIFF_ID_END && id_shift != wrhp_pkg::ID_RIFF) begin
							err_n = wrhp_pkg::STATUS_BAD_HEADER;
						end
						if (off_q == wrhp_pkg::FILE_HDR_END) begin
							if (id_shift != wrhp_pkg::ID_WAVE) begin
								err_n = wrhp_pkg::STATUS_BAD_HEADER;
							end
							phase_n = wrhp_pkg::PH_HEAD;
							off_n   = '0;
						end else begin
							off_n = off_inc;
						end
					end
					wrhp_pkg::PH_HEAD: begin
						id_n   = hdr_id;
						size_n = hdr_size;
						off_n  = off_inc;
						if (off_inc == wrhp_pkg::CHUNK_HDR_LEN) begin
							off_n  = '0;
							pend_n = 1'b0;
							if (hdr_id == wrhp_pkg::ID_FMT) begin
								if (hdr_size < wrhp_pkg::FMT_MIN_SIZE) begin
									pend_n = 1'b1;
								end else begin
									seen_fmt_n = 1'b1;
								end
							end else if (hdr_id == wrhp_pkg::ID_DATA) begin
								coff_n      = pos_ext[wrhp_pkg::DESC_POS_W-1:0];
								csize_n     = hdr_size;
								seen_data_n = 1'b1;
							end
							if (hdr_size == '0) begin
								if (pend_n) begin
									err_n = wrhp_pkg::STATUS_FMT_SHORT;
								end
							end else begin
								phase_n = wrhp_pkg::PH_BODY;
							end
						end
					end
					wrhp_pkg::PH_BODY: begin
						// capture fmt fields by byte lane within the body
						if (id_q == wrhp_pkg::ID_FMT && !pend_q && off_q[wrhp_pkg::OFFSET_W-1:4] == '0) begin
							case (off_q[3:0])
								4'd0:    fmt_n[7:0]    = b;
								4'd1:    fmt_n[15:8]   = b;
								4'd2:    ch_n[7:0]     = b;
								4'd3:    ch_n[15:8]    = b;
								4'd4:    rate_n[7:0]   = b;
								4'd5:    rate_n[15:8]  = b;
								4'd6:    rate_n[23:16] = b;
								4'd7:    rate_n[31:24] = b;
								4'd14:   bits_n[7:0]   = b;
								4'd15:   bits_n[15:8]  = b;
								default: ;
							endcase
						end
						off_n = off_inc;
						if (off_inc >= {1'b0, size_q}) begin
							off_n = '0;
							if (pend_q) begin
								err_n = wrhp_pkg::STATUS_FMT_SHORT;
							end
							phase_n = size_q[0] ? wrhp_pkg::PH_PAD : wrhp_pkg::PH_HEAD;
						end
					end
					default: begin
						// pad byte: drop it
						phase_n = wrhp_pkg::PH_HEAD;
						off_n   = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			phase_q     <= wrhp_pkg::PH_FILE;
			id_q        <= '0;
			size_q      <= '0;
			off_q       <= '0;
			fmt_q       <= '0;
			ch_q        <= '0;
			rate_q      <= '0;
			bits_q      <= '0;
			coff_q      <= '0;
			csize_q     <= '0;
			seen_fmt_q  <= 1'b0;
			seen_data_q <= 1'b0;
			pend_q      <= 1'b0;
			err_q       <= wrhp_pkg::STATUS_OK;
		end else if (cmd.emit) begin
			pos_q       <= '0;
			phase_q     <= wrhp_pkg::PH_FILE;
			id_q        <= '0;
			size_q      <= '0;
			off_q       <= '0;
			fmt_q       <= '0;
			ch_q        <= '0;
			rate_q      <= '0;
			bits_q      <= '0;
			coff_q      <= '0;
			csize_q     <= '0;
			seen_fmt_q  <= 1'b0;
			seen_data_q <= 1'b0;
			pend_q      <= 1'b0;
			err_q       <= wrhp_pkg::STATUS_OK;
		end else begin
			pos_q       <= pos_n;
			phase_q     <= phase_n;
			id_q        <= id_n;
			size_q      <= size_n;
			off_q       <= off_n;
			fmt_q       <= fmt_n;
			ch_q        <= ch_n;
			rate_q      <= rate_n;
			bits_q      <= bits_n;
			coff_q      <= coff_n;
			csize_q     <= csize_n;
			seen_fmt_q  <= seen_fmt_n;
			seen_data_q <= seen_data_n;
			pend_q      <= pend_n;
			err_q       <= err_n;
		end
	end

	// End-of-file checks in priority order; the latched error wins
	always_comb begin
		if (err_q != wrhp_pkg::STATUS_OK) begin
			pre_err = err_q;
		end else if (phase_q == wrhp_pkg::PH_FILE) begin
			pre_err = wrhp_pkg::STATUS_BAD_HEADER;
		end else if (phase_q == wrhp_pkg::PH_BODY) begin
			pre_err = wrhp_pkg::STATUS_TRUNCATED;
		end else if (!seen_fmt_q) begin
			pre_err = wrhp_pkg::STATUS_NO_FMT;
		end else if (!seen_data_q) begin
			pre_err = wrhp_pkg::STATUS_NO_DATA;
		end else if (fmt_q != wrhp_pkg::FORMAT_PCM) begin
			pre_err = wrhp_pkg::STATUS_NOT_PCM;
		end else if (ch_q == '0 || bits_q == '0 || bits_q[2:0] != 3'd0) begin
			pre_err = wrhp_pkg::STATUS_BAD_PCM;
		end else begin
			pre_err = wrhp_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			pre_err_q <= pre_err;
			block_q   <= ch_q * bits_q[15:3];
		end
	end

	wrhp_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (csize_q),
		.divisor   (block_q),
		.done      (div_done),
		.quotient  (quotient),
		.remainder (remainder)
	);

	// Descriptor assembly
	always_comb begin
		if (pre_err_q != wrhp_pkg::STATUS_OK) begin
			final_status = pre_err_q;
		end else if (block_q == '0 || remainder != '0) begin
			final_status = wrhp_pkg::STATUS_UNALIGNED;
		end else begin
			final_status = wrhp_pkg::STATUS_OK;
		end
		show_fields = (final_status == wrhp_pkg::STATUS_OK) ||
			(final_status inside {[wrhp_pkg::STATUS_NOT_PCM:wrhp_pkg::STATUS_UNALIGNED]});
		desc_n        = '0;
		desc_n.status = final_status;
		if (show_fields) begin
			desc_n.format_tag     = fmt_q;
			desc_n.channel_count  = ch_q;
			desc_n.sample_rate    = rate_q;
			desc_n.sample_bits    = bits_q;
			desc_n.payload_offset = coff_q;
			desc_n.payload_size   = csize_q;
			if (final_status == wrhp_pkg::STATUS_OK) begin
				desc_n.frame_total = quotient;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= desc_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_item        = out_q;
	assign status.div_done = div_done;
	assign status.out_busy = out_valid_q && !out_ready;

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.emit))
		else $error("descriptor valid without emit");

	a_frames_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.status == wrhp_pkg::STATUS_OK || out_q.frame_total == '0))
		else $error("frame count on an error descriptor");

endmodule

`default_nettype wire
